FILE: hdl/dhcp_lt_pkg.sv
`default_nettype none

package dhcp_lt_pkg;

    // lease table geometry
    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    typedef logic [7:0]  byte_t;
    typedef logic [47:0] mac_t;
    typedef logic [31:0] ip_t;

    // header checks
    localparam ip_t   MAGIC_COOKIE  = 32'h6382_5363;
    localparam byte_t BOOT_REQUEST  = 8'd1;
    localparam byte_t HTYPE_ETHER   = 8'd1;
    localparam byte_t HLEN_ETHER    = 8'd6;
    localparam byte_t TYPE_OPT_LEN  = 8'd1;
    localparam byte_t MSG_DISCOVER  = 8'd1;
    localparam byte_t MSG_REQUEST   = 8'd3;

    // reset values
    localparam ip_t SERVER_IP_RESET   = 32'h0000_0000;
    localparam ip_t SUBNET_MASK_RESET = 32'hFFFF_FF00;
    localparam ip_t OFFSET_RESET      = 32'h0000_0001;

    typedef enum logic [1:0] {
        KIND_DROP  = 2'd0,
        KIND_OFFER = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_NAK   = 2'd3
    } kind_t;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SERVER_IP   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SUBNET_MASK = 1'b1;

    typedef struct packed {
        ip_t server_ip;
        ip_t subnet_mask;
    } cfg_t;

    // one captured request
    typedef struct packed {
        byte_t boot_op;
        byte_t hw_type;
        byte_t hw_len;
        ip_t   magic_word;
        byte_t msg_type_len;
        byte_t msg_type;
        mac_t  client_mac;
        logic  req_ip_present;
        ip_t   req_ip;
    } item_t;

    // one table entry in memory
    typedef struct packed {
        mac_t mac;
        ip_t  ip;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic             take;
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             alloc;
        logic             load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic hdr_ok;
        logic lease_ok;
        logic rd_pending;
        logic alloc_ok;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/dhcp_lt_if.sv
`default_nettype none

// request channel
interface dhcp_lt_req_if;
    import dhcp_lt_pkg::*;

    logic  valid;
    logic  ready;
    byte_t boot_op;
    byte_t hw_type;
    byte_t hw_len;
    ip_t   magic_word;
    byte_t msg_type_len;
    byte_t msg_type;
    mac_t  client_mac;
    logic  req_ip_present;
    ip_t   req_ip;

    modport source (
        output valid, boot_op, hw_type, hw_len, magic_word, msg_type_len, msg_type,
               client_mac, req_ip_present, req_ip,
        input  ready
    );

    modport sink (
        input  valid, boot_op, hw_type, hw_len, magic_word, msg_type_len, msg_type,
               client_mac, req_ip_present, req_ip,
        output ready
    );
endinterface

// reply channel
interface dhcp_lt_rsp_if;
    import dhcp_lt_pkg::*;

    logic  valid;
    logic  ready;
    kind_t reply_kind;
    ip_t   client_ip;

    modport source (
        output valid, reply_kind, client_ip,
        input  ready
    );

    modport sink (
        input  valid, reply_kind, client_ip,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/dhcp_lt_regs.sv
`default_nettype none

module dhcp_lt_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dhcp_lt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dhcp_lt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dhcp_lt_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output dhcp_lt_pkg::cfg_t                  cfg
);
    import dhcp_lt_pkg::*;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    ip_t                  server_ip_reg;
    ip_t                  subnet_mask_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_ip_reg   <= SERVER_IP_RESET;
            subnet_mask_reg <= SUBNET_MASK_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SERVER_IP:   server_ip_reg   <= pwdata;
                REG_SUBNET_MASK: subnet_mask_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_SERVER_IP:   prdata = server_ip_reg;
            REG_SUBNET_MASK: prdata = subnet_mask_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.server_ip   = server_ip_reg;
    assign cfg.subnet_mask = subnet_mask_reg;

endmodule

`default_nettype wire

FILE: hdl/dhcp_lt_ctrl.sv
`default_nettype none

module dhcp_lt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dhcp_lt_pkg::dp_stat_t stat,
    output dhcp_lt_pkg::dp_cmd_t  cmd
);
    import dhcp_lt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_ALLOC  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] issue_idx_reg;
    logic [CNT_W-1:0] issue_idx_next;
    logic             issue_left;

    assign issue_left = (issue_idx_reg < CNT_W'(TABLE_ENTRIES));

    // sequencing of one request
    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        cmd            = '0;
        cmd.rd_addr    = issue_idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.start      = 1'b1;
                issue_idx_next = '0;
                state_next     = stat.hdr_ok ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (stat.lease_ok)
                begin
                    state_next = ST_FINISH;
                end
                else if (issue_left)
                begin
                    cmd.rd_en      = 1'b1;
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                else if (!stat.rd_pending)
                begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dhcp_lt_dp.sv
`default_nettype none

module dhcp_lt_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dhcp_lt_pkg::cfg_t     cfg,
    input  dhcp_lt_pkg::dp_cmd_t  cmd,
    output dhcp_lt_pkg::dp_stat_t stat,
    dhcp_lt_req_if.sink           req,
    dhcp_lt_rsp_if.source         rsp
);
    import dhcp_lt_pkg::*;

    // lease memory: mac and address of every slot
    slot_t              mem [TABLE_ENTRIES];

    item_t              item_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    ip_t                next_offset_reg;
    slot_t              rd_data_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               lease_ok_reg;
    ip_t                lease_ip_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               out_valid_reg;
    kind_t              kind_reg;
    ip_t                ip_out_reg;

    logic               in_fire;
    logic               hdr_ok;
    logic               hit;
    logic               free_seen;
    ip_t                cand_addr;
    logic               addr_ok;
    logic               alloc_we;
    slot_t              new_slot;
    kind_t              kind_next;

    assign req.ready = cmd.take;
    assign in_fire   = req.valid & cmd.take;

    // capture the request
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.boot_op        <= req.boot_op;
            item_reg.hw_type        <= req.hw_type;
            item_reg.hw_len         <= req.hw_len;
            item_reg.magic_word     <= req.magic_word;
            item_reg.msg_type_len   <= req.msg_type_len;
            item_reg.msg_type       <= req.msg_type;
            item_reg.client_mac     <= req.client_mac;
            item_reg.req_ip_present <= req.req_ip_present;
            item_reg.req_ip         <= req.req_ip;
        end
    end

    // header validation
    assign hdr_ok = (item_reg.boot_op == BOOT_REQUEST) &&
                    (item_reg.magic_word == MAGIC_COOKIE) &&
                    (item_reg.hw_type == HTYPE_ETHER) &&
                    (item_reg.hw_len == HLEN_ETHER) &&
                    (item_reg.msg_type_len == TYPE_OPT_LEN) &&
                    ((item_reg.msg_type == MSG_DISCOVER) ||
                     (item_reg.msg_type == MSG_REQUEST));

    // compare the slot read last cycle
    assign hit       = rd_valid_reg && used_reg[rd_idx_reg] && !lease_ok_reg &&
                       (rd_data_reg.mac == item_reg.client_mac);
    assign free_seen = rd_valid_reg && !used_reg[rd_idx_reg] && !free_found_reg;

    // candidate address for a new lease
    assign cand_addr = (cfg.server_ip & ~cfg.subnet_mask) + next_offset_reg;
    assign addr_ok   = ((cand_addr & cfg.subnet_mask) == '0);
    assign alloc_we  = cmd.alloc && free_found_reg && addr_ok;
    assign new_slot.mac = item_reg.client_mac;
    assign new_slot.ip  = cand_addr | (cfg.subnet_mask & cfg.server_ip);

    // memory port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            mem[free_idx_reg] <= new_slot;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // lookup and allocation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            next_offset_reg <= OFFSET_RESET;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            lease_ok_reg    <= 1'b0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            rd_idx_reg   <= cmd.rd_addr;
            if (cmd.start)
            begin
                lease_ok_reg   <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (hit || alloc_we)
                begin
                    lease_ok_reg <= 1'b1;
                end
                if (free_seen)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
            end
            if (alloc_we)
            begin
                used_reg[free_idx_reg] <= 1'b1;
                next_offset_reg        <= next_offset_reg + 32'd1;
            end
        end
    end

    // leased address of the client
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            lease_ip_reg <= rd_data_reg.ip;
        end
        else if (alloc_we)
        begin
            lease_ip_reg <= new_slot.ip;
        end
    end

    // reply decision
    always_comb
    begin
        if (!lease_ok_reg)
        begin
            kind_next = KIND_DROP;
        end
        else if (item_reg.msg_type == MSG_DISCOVER)
        begin
            kind_next = KIND_OFFER;
        end
        else if (item_reg.req_ip_present && (item_reg.req_ip != lease_ip_reg))
        begin
            kind_next = KIND_NAK;
        end
        else
        begin
            kind_next = KIND_ACK;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            kind_reg   <= kind_next;
            ip_out_reg <= lease_ok_reg ? lease_ip_reg : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.reply_kind = kind_reg;
    assign rsp.client_ip  = ip_out_reg;

    assign stat.in_valid   = req.valid;
    assign stat.hdr_ok     = hdr_ok;
    assign stat.lease_ok   = lease_ok_reg;
    assign stat.rd_pending = rd_valid_reg;
    assign stat.alloc_ok   = free_found_reg && addr_ok;
    assign stat.out_free   = !out_valid_reg || rsp.ready;

endmodule

`default_nettype wire

FILE: hdl/dhcp_lease_table.sv
// DHCP lease table: decides the answer to one decoded client message.
// req channel: valid/ready transfer of the header fields, message type,
// client MAC and optional requested address. rsp channel: valid/ready
// transfer of reply_kind (drop, offer, ack, nak) and the client address.
// Server address and subnet mask are to be written by the user over the
// APB port while idle; the block does not enforce this. Each message
// gives exactly one reply, in order. A bad header skips the lookup and
// goes straight to the reply. A lookup reads the lease memory one slot
// per cycle; a known client's slot ends the scan, while a new lease is
// allocated only after every slot is read. One message is handled at a
// time; the next transfer is taken the cycle after the reply is loaded.
// The reply sits in an output register: the next message is taken while
// it waits, and a stalled receiver holds the following reply back.
// Reset clears all leases, sets the running offset to 1, the server
// address to 0 and the mask to 255.255.255.0; no clearing pass is needed.
`default_nettype none

module dhcp_lease_table (
    input  logic                               clk,
    input  logic                               rst_n,
    dhcp_lt_req_if.sink                        req,
    dhcp_lt_rsp_if.source                      rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dhcp_lt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dhcp_lt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dhcp_lt_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import dhcp_lt_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers
    dhcp_lt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    dhcp_lt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // lookup, allocation and reply
    dhcp_lt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef NO_ASSERTIONS
    // a taken request makes the block busy
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while a previous one is in progress");

    // a new slot is only taken when the scan found no lease
    a_alloc_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !stat.lease_ok)
        else $error("allocation attempted for a client that already has a lease");

    // the reply is loaded only into a free output register
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("reply overwrote one not yet transferred");

    // memory reads only happen during a lookup
    a_read_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (!req.ready && !cmd.load_out && !cmd.alloc))
        else $error("lease memory read outside a lookup");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
module testbench;
    import dhcp_lt_pkg::*;

    // message types the block must refuse
    localparam byte_t MSG_OFFER   = 8'd2;
    localparam byte_t MSG_DECLINE = 8'd4;
    localparam int    CYCLE_LIMIT = 300000;

    typedef struct packed {
        kind_t kind;
        ip_t   ip;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    dhcp_lt_req_if req_ch ();
    dhcp_lt_rsp_if rsp_ch ();

    dhcp_lease_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // lease table as the testbench sees it
    logic  lease_used [TABLE_ENTRIES];
    mac_t  lease_mac  [TABLE_ENTRIES];
    ip_t   lease_ip   [TABLE_ENTRIES];
    ip_t   lease_offset;
    ip_t   cfg_server_ip;
    ip_t   cfg_subnet_mask;

    reply_t replies_due [$];

    int error_count     = 0;
    int cycle_count     = 0;
    int messages_sent   = 0;
    int replies_checked = 0;
    int config_writes   = 0;
    int kind_count [4]  = '{0, 0, 0, 0};

    // idling controls shared with the reply sink
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int sink_hold   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decide the reply to one message and update the lease table
    function automatic reply_t lease_decide(input item_t m);
        reply_t r;
        int     slot;
        int     free_slot;
        int     i;
        ip_t    addr;
        r.kind = KIND_DROP;
        r.ip   = '0;
        if (m.boot_op != BOOT_REQUEST || m.magic_word != MAGIC_COOKIE ||
            m.hw_type != HTYPE_ETHER || m.hw_len != HLEN_ETHER ||
            m.msg_type_len != TYPE_OPT_LEN ||
            (m.msg_type != MSG_DISCOVER && m.msg_type != MSG_REQUEST))
            return r;
        slot      = -1;
        free_slot = -1;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (lease_used[i])
            begin
                if (lease_mac[i] == m.client_mac && slot < 0)
                    slot = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        // unknown client: new lease in the first free slot, if the subnet has room
        if (slot < 0)
        begin
            if (free_slot < 0)
                return r;
            addr = (cfg_server_ip & ~cfg_subnet_mask) + lease_offset;
            if ((addr & cfg_subnet_mask) != '0)
                return r;
            lease_offset          = lease_offset + 1;
            lease_used[free_slot] = 1'b1;
            lease_mac[free_slot]  = m.client_mac;
            lease_ip[free_slot]   = addr | (cfg_subnet_mask & cfg_server_ip);
            slot                  = free_slot;
        end
        r.ip = lease_ip[slot];
        if (m.msg_type == MSG_DISCOVER)
            r.kind = KIND_OFFER;
        else if (m.req_ip_present && m.req_ip != r.ip)
            r.kind = KIND_NAK;
        else
            r.kind = KIND_ACK;
        return r;
    endfunction

    function automatic item_t client_message(input mac_t mac, input byte_t mtype,
                                             input logic present, input ip_t rip);
        item_t m;
        m.boot_op        = BOOT_REQUEST;
        m.hw_type        = HTYPE_ETHER;
        m.hw_len         = HLEN_ETHER;
        m.magic_word     = MAGIC_COOKIE;
        m.msg_type_len   = TYPE_OPT_LEN;
        m.msg_type       = mtype;
        m.client_mac     = mac;
        m.req_ip_present = present;
        m.req_ip         = rip;
        return m;
    endfunction

    function automatic mac_t fresh_mac();
        mac_t mac;
        mac[47:32] = 16'($urandom);
        mac[31:0]  = $urandom;
        return mac;
    endfunction

    // offer one message and record its expected reply at the transfer
    task automatic send_message(input item_t m);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.boot_op        <= m.boot_op;
        req_ch.hw_type        <= m.hw_type;
        req_ch.hw_len         <= m.hw_len;
        req_ch.magic_word     <= m.magic_word;
        req_ch.msg_type_len   <= m.msg_type_len;
        req_ch.msg_type       <= m.msg_type;
        req_ch.client_mac     <= m.client_mac;
        req_ch.req_ip_present <= m.req_ip_present;
        req_ch.req_ip         <= m.req_ip;
        do @(posedge clk); while (!req_ch.ready);
        replies_due.push_back(lease_decide(m));
        messages_sent++;
        @(negedge clk);
    endtask

    // stop offering and let every outstanding reply come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic read_register(input logic [REG_IDX_W-1:0] idx, input ip_t want);
        ip_t value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (value !== want)
        begin
            $display("%0t ERROR register %0d read: expected %h, got %h",
                     $time, idx, want, value);
            error_count++;
        end
    endtask

    task automatic set_register(input logic [REG_IDX_W-1:0] idx, input ip_t value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_SERVER_IP)
            cfg_server_ip = value;
        else
            cfg_subnet_mask = value;
        config_writes++;
        read_register(idx, value);
    endtask

    // reset values and the first lease under them
    task automatic test_reset_defaults();
        read_register(REG_SERVER_IP, SERVER_IP_RESET);
        read_register(REG_SUBNET_MASK, SUBNET_MASK_RESET);
        send_message(client_message('0, MSG_DISCOVER, 1'b0, '0));
    endtask

    // every header check on its own, then proof that nothing was allocated
    task automatic test_header_checks();
        item_t m;
        int    n;
        for (n = 0; n < 12; n++)
        begin
            m = client_message('1, MSG_REQUEST, 1'b0, $urandom);
            case (n)
                0:  m.boot_op      = 8'h00;
                1:  m.boot_op      = 8'hFF;
                2:  m.magic_word   = ~MAGIC_COOKIE;
                3:  m.magic_word   = MAGIC_COOKIE ^ (32'h1 << $urandom_range(0, 31));
                4:  m.hw_type      = 8'h00;
                5:  m.hw_type      = 8'hFF;
                6:  m.hw_len       = 8'(HLEN_ETHER - 1);
                7:  m.msg_type_len = 8'h00;
                8:  m.msg_type_len = 8'hFF;
                9:  m.msg_type     = 8'h00;
                10: m.msg_type     = MSG_OFFER;
                default: m.msg_type = 8'hFF;
            endcase
            send_message(m);
        end
        send_message(client_message('1, MSG_DISCOVER, 1'b1, $urandom));
    endtask

    // offer, ack, nak and absent address on a configured server
    task automatic test_lease_answers();
        mac_t mac;
        ip_t  next_ip;
        set_register(REG_SERVER_IP, 32'hC0A8_0A01);
        set_register(REG_SUBNET_MASK, 32'hFFFF_FF00);
        mac     = fresh_mac();
        next_ip = ((cfg_server_ip & ~cfg_subnet_mask) + lease_offset) |
                  (cfg_subnet_mask & cfg_server_ip);
        send_message(client_message(mac, MSG_REQUEST, 1'b1, next_ip));
        send_message(client_message(mac, MSG_REQUEST, 1'b1, next_ip ^ 32'h8000_0000));
        send_message(client_message(mac, MSG_REQUEST, 1'b0, ~next_ip));
        send_message(client_message(mac, MSG_DISCOVER, 1'b1, $urandom));
        send_message(client_message('0, MSG_DISCOVER, 1'b0, '0));
        send_message(client_message(fresh_mac(), MSG_REQUEST, 1'b0, '0));
    endtask

    // no host bits, host part wrapping past zero, host part with no room
    task automatic test_subnet_limits();
        mac_t mac;
        mac = fresh_mac();
        set_register(REG_SUBNET_MASK, 32'hFFFF_FFFF);
        send_message(client_message(mac, MSG_DISCOVER, 1'b0, '0));
        set_register(REG_SERVER_IP, 32'hFFFF_FFFF);
        set_register(REG_SUBNET_MASK, 32'h0000_0000);
        send_message(client_message(mac, MSG_DISCOVER, 1'b0, '0));
        set_register(REG_SUBNET_MASK, 32'hFFFF_FFFC);
        send_message(client_message(fresh_mac(), MSG_DISCOVER, 1'b0, '0));
    endtask

    // fill every slot, then new clients are refused while known ones still get answers
    task automatic test_table_full();
        bit full;
        int i;
        set_register(REG_SERVER_IP, $urandom);
        set_register(REG_SUBNET_MASK, 32'h0000_0000);
        full = 1'b0;
        while (!full)
        begin
            full = 1'b1;
            for (i = 0; i < TABLE_ENTRIES; i++)
                if (!lease_used[i])
                    full = 1'b0;
            if (!full)
                send_message(client_message(fresh_mac(), MSG_DISCOVER, 1'b0, '0));
        end
        send_message(client_message(fresh_mac(), MSG_DISCOVER, 1'b0, '0));
        send_message(client_message(fresh_mac(), MSG_REQUEST, 1'b1, $urandom));
        send_message(client_message(lease_mac[TABLE_ENTRIES-1], MSG_REQUEST, 1'b1,
                                    lease_ip[TABLE_ENTRIES-1]));
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        int n;
        src_steady  = 1'b1;
        sink_steady = 1'b0;
        sink_hold   = 150;
        for (n = 0; n < 12; n++)
            send_message(client_message(lease_mac[n % TABLE_ENTRIES], MSG_REQUEST,
                                        1'($urandom), lease_ip[$urandom_range(0, 7)]));
        src_steady = 1'b0;
    endtask

    // mostly well-formed traffic from known clients, some new, some broken
    task automatic test_random_traffic(input int count);
        item_t m;
        int    n;
        int    slot;
        mac_t  mac;
        ip_t   rip;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            slot = $urandom_range(0, TABLE_ENTRIES - 1);
            mac  = (lease_used[slot] && $urandom_range(0, 4) != 0) ?
                   lease_mac[slot] : fresh_mac();
            rip  = (lease_used[slot] && $urandom_range(0, 1) != 0) ?
                   lease_ip[slot] : ip_t'($urandom);
            m = client_message(mac, $urandom_range(0, 1) ? MSG_DISCOVER : MSG_REQUEST,
                               1'($urandom), rip);
            if ($urandom_range(0, 99) >= 80)
            begin
                case ($urandom_range(0, 6))
                    0: m.boot_op      = 8'($urandom);
                    1: m.hw_type      = 8'($urandom);
                    2: m.hw_len       = 8'($urandom);
                    3: m.magic_word   = $urandom;
                    4: m.msg_type_len = 8'($urandom);
                    5: m.msg_type     = $urandom_range(0, 1) ? MSG_DECLINE : 8'($urandom);
                    default:
                    begin
                        m.boot_op      = 8'($urandom);
                        m.hw_type      = 8'($urandom);
                        m.hw_len       = 8'($urandom);
                        m.magic_word   = $urandom;
                        m.msg_type_len = 8'($urandom);
                        m.msg_type     = 8'($urandom);
                    end
                endcase
            end
            send_message(m);
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // reply sink: random stalls per transfer, or a long hold-off on request
    initial
    begin : reply_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        @(negedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            else if (sink_steady)
                stall = 0;
            else
                stall = $urandom_range(0, 18);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    // compare each reply transfer with the oldest expectation
    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t ERROR reply with none expected: expected nothing, got kind %0d ip %h",
                         $time, rsp_ch.reply_kind, rsp_ch.client_ip);
                error_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                replies_checked++;
                kind_count[want.kind]++;
                if (rsp_ch.reply_kind !== want.kind)
                begin
                    $display("%0t ERROR reply_kind: expected %0d, got %0d",
                             $time, want.kind, rsp_ch.reply_kind);
                    error_count++;
                end
                if (rsp_ch.client_ip !== want.ip)
                begin
                    $display("%0t ERROR client_ip: expected %h, got %h",
                             $time, want.ip, rsp_ch.client_ip);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ERROR timeout after %0d cycles, %0d replies outstanding",
                     $time, cycle_count, replies_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.boot_op        <= '0;
        req_ch.hw_type        <= '0;
        req_ch.hw_len         <= '0;
        req_ch.magic_word     <= '0;
        req_ch.msg_type_len   <= '0;
        req_ch.msg_type       <= '0;
        req_ch.client_mac     <= '0;
        req_ch.req_ip_present <= 1'b0;
        req_ch.req_ip         <= '0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            lease_used[i] = 1'b0;
            lease_mac[i]  = '0;
            lease_ip[i]   = '0;
        end
        lease_offset    = OFFSET_RESET;
        cfg_server_ip   = SERVER_IP_RESET;
        cfg_subnet_mask = SUBNET_MASK_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_header_checks();
        test_lease_answers();
        test_subnet_limits();

        // remaining slots fill up under a /24 with a small host part
        set_register(REG_SERVER_IP, {24'($urandom), 8'h10});
        set_register(REG_SUBNET_MASK, 32'hFFFF_FF00);
        test_random_traffic(240);

        test_table_full();
        test_backpressure();

        set_register(REG_SERVER_IP, $urandom);
        set_register(REG_SUBNET_MASK, $urandom);
        test_random_traffic(240);

        set_register(REG_SERVER_IP, 32'h0000_0000);
        set_register(REG_SUBNET_MASK, 32'hFFFF_FFFF);
        test_random_traffic(240);

        // drain, then allow for the slowest lookup
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (TABLE_ENTRIES + 12) @(posedge clk);

        $display("covered %0d messages and %0d replies: %0d offer, %0d ack, %0d nak, %0d dropped",
                 messages_sent, replies_checked, kind_count[KIND_OFFER],
                 kind_count[KIND_ACK], kind_count[KIND_NAK], kind_count[KIND_DROP]);
        $display("%0d leases granted across %0d register writes, with a long receiver hold-off",
                 lease_offset - OFFSET_RESET, config_writes);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dhcp_lt_pkg.sv
hdl/dhcp_lt_if.sv
hdl/dhcp_lt_regs.sv
hdl/dhcp_lt_ctrl.sv
hdl/dhcp_lt_dp.sv
hdl/dhcp_lease_table.sv
tb/testbench.sv
